[hw/rtl/erq_pkg.sv]
package erq_pkg;

  // Default geometry of the queue
  localparam int DEPTH_DEF      = 16;
  localparam int EVENT_BITS_DEF = 8;

  // Fixed field widths on the channels
  localparam int MODE_W     = 3;
  localparam int EVENT_W    = 8;
  localparam int SLOT_IN_W  = 8;
  localparam int FILL_W     = 5;

  // Operation codes; the two unused codes fall to the default arm
  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ   = 3'd0,
    MODE_DEQ   = 3'd1,
    MODE_SET   = 3'd2,
    MODE_TRIG  = 3'd3,
    MODE_DUMP  = 3'd4,
    MODE_READ  = 3'd5
  } mode_e;

  typedef struct packed {
    mode_e                 mode;
    logic [EVENT_W-1:0]    event_id;
    logic                  keep_cache;
    logic [SLOT_IN_W-1:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0]    event_out;
    logic                  slot_ok;
    logic                  overflow;
    logic [FILL_W-1:0]     fill_count;
  } out_item_t;

endpackage

[hw/rtl/erq_if.sv]
// Input channel: one operation per beat
interface erq_in_if;
  logic              valid;
  logic              ready;
  erq_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Output channel: one result per beat
interface erq_out_if;
  logic               valid;
  logic               ready;
  erq_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/event_ring_queue.sv]
// Ring queue of event codes with overflow flag and one cached event.
//
// Channels: in_i carries one operation per beat (enqueue, dequeue, set cache,
// trigger, dump, read slot); out_o returns exactly one result beat for every
// accepted operation, in order: event code, slot_ok, overflow flag and fill
// count as they stand after the operation.
//
// The result is registered and valid in the cycle after its input beat is
// accepted. Throughput: one operation per cycle unless a result stalls.
// All state is updated at the accept edge from the queue registers and
// per-slot non-null flags; the slot memory is read on its read port at the
// same edge, and its registered read data forms part of the result register.
//
// Reset: pointers, count, overflow flag, cache and all non-null flags clear
// at once, so every slot reads as the null event; the block accepts beats
// right after reset is released.
//
// Stall: while a result waits with out_o.ready low, in_i.ready is low and the
// result holds; when the receiver takes it, a new beat can enter that cycle.
module event_ring_queue #(
  parameter int DEPTH      = erq_pkg::DEPTH_DEF,
  parameter int EVENT_BITS = erq_pkg::EVENT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  erq_in_if.sink    in_i,
  erq_out_if.source out_o
);
  import erq_pkg::*;

  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SLOT_EXT_W = SLOT_IN_W + 1;

  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]      FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [SLOT_EXT_W-1:0] DEPTH_EXT = SLOT_EXT_W'(DEPTH);

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  // Slot storage and queue state
  logic [EVENT_BITS-1:0] mem [DEPTH];
  logic [EVENT_BITS-1:0] rdata_q;
  logic [DEPTH-1:0]      nz_q, nz_d;
  logic [IDX_W-1:0]      wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic [EVENT_BITS-1:0] cache_q, cache_d;

  // Result register
  logic                  res_valid_q;
  logic                  res_sel_q, res_sel_d;
  logic                  res_ok_q, res_ok_d;
  logic                  res_ovf_q;
  logic [FILL_W-1:0]     res_cnt_q;
  logic [EVENT_W-1:0]    res_event;

  logic                  accept;
  logic [EVENT_BITS-1:0] ev;
  logic                  push_req;
  logic [EVENT_BITS-1:0] push_val;
  logic                  mem_we;
  logic [EVENT_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]      raddr;
  logic [IDX_W-1:0]      slot_idx;

  assign in_i.ready = !res_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign ev         = EVENT_BITS'(in_i.data.event_id);
  assign slot_idx   = in_i.data.slot_index[IDX_W-1:0];

  // Next state for the operation on the channel
  always_comb begin
    nz_d      = nz_q;
    wr_idx_d  = wr_idx_q;
    rd_idx_d  = rd_idx_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    cache_d   = cache_q;
    push_req  = 1'b0;
    push_val  = ev;
    mem_we    = 1'b0;
    mem_wdata = ev;
    raddr     = rd_idx_q;
    res_sel_d = 1'b0;
    res_ok_d  = 1'b1;

    unique case (in_i.data.mode)
      MODE_ENQ: begin
        push_req = 1'b1;
      end
      MODE_DEQ: begin
        if (cnt_q != '0 && nz_q[rd_idx_q]) begin
          res_sel_d      = 1'b1;
          nz_d[rd_idx_q] = 1'b0;
          rd_idx_d       = wrap_next(rd_idx_q);
          cnt_d          = cnt_q - 1'b1;
        end else begin
          // empty or null head: restart the ring
          rd_idx_d = '0;
          wr_idx_d = '0;
          cnt_d    = '0;
        end
        ovf_d = 1'b0;
      end
      MODE_SET: begin
        cache_d = ev;
      end
      MODE_TRIG: begin
        if (cache_q != '0) begin
          push_req = 1'b1;
          push_val = cache_q;
          if (!in_i.data.keep_cache) begin
            cache_d = '0;
          end
        end
      end
      MODE_DUMP: begin
        nz_d     = '0;
        wr_idx_d = '0;
        rd_idx_d = '0;
        cnt_d    = '0;
      end
      MODE_READ: begin
        if (SLOT_EXT_W'(in_i.data.slot_index) < DEPTH_EXT) begin
          raddr     = slot_idx;
          res_sel_d = nz_q[slot_idx];
        end else begin
          res_ok_d = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // Shared push path for enqueue and trigger
    if (push_req && !ovf_q) begin
      if (cnt_q < FULL_CNT) begin
        mem_we         = 1'b1;
        mem_wdata      = push_val;
        nz_d[wr_idx_q] = (push_val != '0);
        wr_idx_d       = wrap_next(wr_idx_q);
        cnt_d          = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
        cnt_d = FULL_CNT;
      end
    end
  end

  // Queue state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q     <= '0;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      cache_q  <= '0;
    end else if (accept) begin
      nz_q     <= nz_d;
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      cache_q  <= cache_d;
    end
  end

  // Slot memory write port
  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      mem[wr_idx_q] <= mem_wdata;
    end
  end

  // Slot memory read port, data held with the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem[raddr];
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_sel_q <= res_sel_d;
      res_ok_q  <= res_ok_d;
      res_ovf_q <= ovf_d;
      res_cnt_q <= FILL_W'(cnt_d);
    end
  end

  assign res_event   = res_sel_q ? EVENT_W'(rdata_q) : '0;
  assign out_o.valid = res_valid_q;
  assign out_o.data  = '{event_out:  res_event,
                         slot_ok:    res_ok_q,
                         overflow:   res_ovf_q,
                         fill_count: res_cnt_q};

endmodule

[hw/rtl/erq_checker.sv]
module erq_sva (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input erq_pkg::mode_e     in_mode_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input erq_pkg::out_item_t out_data_i
);
  import erq_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // Every accepted beat has its result on the next cycle
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> out_valid_i)
    else $error("no result one cycle after an accepted beat");

  // A dequeue always leaves the overflow flag clear
  a_deq_clears_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_mode_i == MODE_DEQ |=> !out_data_i.overflow)
    else $error("overflow still set after dequeue");

  // Only read slot can report a bad index
  a_ok_outside_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_mode_i != MODE_READ |=> out_data_i.slot_ok)
    else $error("slot_ok low on an operation other than read slot");

  // A bad index returns the null event
  a_bad_slot_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.slot_ok |-> out_data_i.event_out == '0)
    else $error("event returned for an out-of-range slot");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

endmodule

bind event_ring_queue erq_sva u_erq_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.data.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
